// ===== hw/rtl/cvr_pkg.sv =====
// Shared types, constants and helper functions for the camera vector rotator.
package cvr_pkg;

    // Sizing
    localparam int VECTOR_BITS  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int GUARD_BITS   = 16;
    localparam int ANGLE_BITS   = 24;
    localparam int Z_BITS       = ANGLE_BITS + 1;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);
    localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    // Datapath widths: CORDIC word carries guard bits plus headroom for gain
    localparam int CW      = VECTOR_BITS + GUARD_BITS + 3;
    localparam int RW      = CW - GUARD_BITS;
    localparam int MB      = (VECTOR_BITS > GUARD_BITS + 1) ? VECTOR_BITS : GUARD_BITS + 1;
    localparam int MCNT_W  = $clog2(MB);
    localparam int GAIN_W  = 32;
    localparam int HI_W    = GAIN_W + MB - GUARD_BITS;

    // CORDIC gain inverse, Q0.32
    localparam logic [GAIN_W-1:0] GAIN_INV = 32'h9B74EDA8;

    localparam longint VEC_MAX = (64'sd1 <<< (VECTOR_BITS - 1)) - 64'sd1;
    localparam longint VEC_MIN = -VEC_MAX - 64'sd1;

    localparam logic signed [Z_BITS-1:0] QUARTER_TURN = Z_BITS'(4194304);

    // Configuration register indexes
    localparam logic [1:0] CFG_CENTER_COLUMN = 2'd0;
    localparam logic [1:0] CFG_ANGLE_STEP    = 2'd1;
    localparam logic [1:0] CFG_MOUSE_LOOK_ON = 2'd2;

    typedef logic signed [VECTOR_BITS-1:0] vec_t;
    typedef logic signed [CW-1:0]          cw_t;
    typedef logic signed [ANGLE_BITS-1:0]  angle_t;
    typedef logic signed [Z_BITS-1:0]      z_t;

    // Clamp an integer to the vector range
    function automatic vec_t sat_int(input longint v);
        longint t;
        t = v;
        if (t > VEC_MAX) t = VEC_MAX;
        if (t < VEC_MIN) t = VEC_MIN;
        return VECTOR_BITS'(t);
    endfunction

    // Low 16 bits of a vector, sign extended where the vector is narrower
    function automatic logic [15:0] out16(input vec_t v);
        longint t;
        t = longint'(v);
        return t[15:0];
    endfunction

    localparam vec_t DIR_X_RST   = sat_int(64'sd16384);
    localparam vec_t DIR_Y_RST   = sat_int(64'sd0);
    localparam vec_t PLANE_X_RST = sat_int(64'sd0);
    localparam vec_t PLANE_Y_RST = sat_int(64'sd10813);

    // Arctangent of 2^-i in 2^-24 turn units
    function automatic z_t atan_turns(input logic [ATAN_IDX_W-1:0] idx);
        z_t r;
        case (idx)
            5'd0:    r = Z_BITS'(2097152);
            5'd1:    r = Z_BITS'(1238021);
            5'd2:    r = Z_BITS'(654136);
            5'd3:    r = Z_BITS'(332050);
            5'd4:    r = Z_BITS'(166669);
            5'd5:    r = Z_BITS'(83416);
            5'd6:    r = Z_BITS'(41718);
            5'd7:    r = Z_BITS'(20860);
            5'd8:    r = Z_BITS'(10430);
            5'd9:    r = Z_BITS'(5215);
            5'd10:   r = Z_BITS'(2608);
            5'd11:   r = Z_BITS'(1304);
            5'd12:   r = Z_BITS'(652);
            5'd13:   r = Z_BITS'(326);
            5'd14:   r = Z_BITS'(163);
            5'd15:   r = Z_BITS'(81);
            5'd16:   r = Z_BITS'(41);
            5'd17:   r = Z_BITS'(20);
            5'd18:   r = Z_BITS'(10);
            5'd19:   r = Z_BITS'(5);
            5'd20:   r = Z_BITS'(3);
            5'd21:   r = Z_BITS'(1);
            5'd22:   r = Z_BITS'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/cvr_gain_mult.sv =====
// Bit-serial multiply of a vector component by the CORDIC gain inverse, with rounding.
module cvr_gain_mult
    import cvr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  vec_t din,
    output logic done,
    output cw_t  prod
);

    logic              run_reg;
    logic [MCNT_W-1:0] cnt_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [MB-1:0]     mag_reg;
    logic [GAIN_W-1:0] acc_reg;
    logic [MB-1:0]     low_reg;

    logic [VECTOR_BITS-1:0] mag_in;
    logic [GAIN_W:0]        sum;
    logic [HI_W-1:0]        hi;
    logic [HI_W-1:0]        rounded;

    // Take the magnitude; the most negative value maps to its unsigned magnitude
    assign mag_in = din[VECTOR_BITS-1] ? (VECTOR_BITS'(0) - $unsigned(din)) : $unsigned(din);

    // Add the gain when the current multiplier bit is set
    assign sum = {1'b0, acc_reg} + (mag_reg[0] ? {1'b0, GAIN_INV} : '0);

    // Round half up at the guard bits and restore the sign
    assign hi      = {acc_reg, low_reg[MB-1:GUARD_BITS]};
    assign rounded = hi + HI_W'(low_reg[GUARD_BITS-1]);
    assign prod    = neg_reg ? (CW'(0) - cw_t'(CW'(rounded))) : cw_t'(CW'(rounded));
    assign done    = done_reg;

    // Shift one multiplier bit per cycle, LSB first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            mag_reg  <= '0;
            acc_reg  <= '0;
            low_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                neg_reg <= din[VECTOR_BITS-1];
                mag_reg <= MB'(mag_in);
                acc_reg <= '0;
                low_reg <= '0;
            end
            else if (run_reg)
            begin
                acc_reg <= sum[GAIN_W:1];
                low_reg <= {sum[0], low_reg[MB-1:1]};
                mag_reg <= {1'b0, mag_reg[MB-1:1]};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MCNT_W'(MB - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/cvr_cordic.sv =====
// Gain-compensated iterative CORDIC rotation of one vector with rounding and saturation.
module cvr_cordic
    import cvr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  angle_t angle,
    input  vec_t   x_in,
    input  vec_t   y_in,
    output logic   done,
    output vec_t   x_out,
    output vec_t   y_out
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCALE, ST_ITER, ST_ROUND} state_t;

    localparam logic signed [RW-1:0] RND_MAX = RW'(VEC_MAX);
    localparam logic signed [RW-1:0] RND_MIN = RW'(VEC_MIN);
    localparam cw_t                  HALF_LSB = cw_t'(CW'(1) << (GUARD_BITS - 1));

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    z_t                z_reg;
    cw_t               x_reg;
    cw_t               y_reg;
    vec_t              x_out_reg;
    vec_t              y_out_reg;

    logic mx_done;
    logic my_done;
    cw_t  mx_prod;
    cw_t  my_prod;

    z_t   z_fold_next;
    cw_t  x_fold_next;
    cw_t  y_fold_next;
    z_t   z_iter_next;
    cw_t  x_iter_next;
    cw_t  y_iter_next;
    cw_t  xs;
    cw_t  ys;
    z_t   atan_v;
    cw_t  x_sum;
    cw_t  y_sum;
    logic signed [RW-1:0] x_rnd;
    logic signed [RW-1:0] y_rnd;
    vec_t x_sat_next;
    vec_t y_sat_next;

    cvr_gain_mult u_mult_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .din   (x_in),
        .done  (mx_done),
        .prod  (mx_prod)
    );

    cvr_gain_mult u_mult_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .din   (y_in),
        .done  (my_done),
        .prod  (my_prod)
    );

    // Bring the angle into a quarter turn either side of zero by exact swaps
    always_comb
    begin
        z_fold_next = z_reg;
        x_fold_next = mx_prod;
        y_fold_next = my_prod;
        if (z_reg > QUARTER_TURN)
        begin
            x_fold_next = CW'(0) - my_prod;
            y_fold_next = mx_prod;
            z_fold_next = z_reg - QUARTER_TURN;
        end
        else if (z_reg < -QUARTER_TURN)
        begin
            x_fold_next = my_prod;
            y_fold_next = CW'(0) - mx_prod;
            z_fold_next = z_reg + QUARTER_TURN;
        end
    end

    // One micro-rotation; a zero residual turns counterclockwise
    always_comb
    begin
        xs     = x_reg >>> step_reg;
        ys     = y_reg >>> step_reg;
        atan_v = atan_turns(ATAN_IDX_W'(step_reg));
        if (!z_reg[Z_BITS-1])
        begin
            x_iter_next = x_reg - ys;
            y_iter_next = y_reg + xs;
            z_iter_next = z_reg - atan_v;
        end
        else
        begin
            x_iter_next = x_reg + ys;
            y_iter_next = y_reg - xs;
            z_iter_next = z_reg + atan_v;
        end
    end

    // Drop the guard bits with rounding and clamp to the vector range
    always_comb
    begin
        x_sum = x_reg + HALF_LSB;
        y_sum = y_reg + HALF_LSB;
        x_rnd = x_sum[CW-1:GUARD_BITS];
        y_rnd = y_sum[CW-1:GUARD_BITS];
        if (x_rnd > RND_MAX)
            x_sat_next = VECTOR_BITS'(RND_MAX);
        else if (x_rnd < RND_MIN)
            x_sat_next = VECTOR_BITS'(RND_MIN);
        else
            x_sat_next = x_rnd[VECTOR_BITS-1:0];
        if (y_rnd > RND_MAX)
            y_sat_next = VECTOR_BITS'(RND_MAX);
        else if (y_rnd < RND_MIN)
            y_sat_next = VECTOR_BITS'(RND_MIN);
        else
            y_sat_next = y_rnd[VECTOR_BITS-1:0];
    end

    // Sequence prescale, micro-steps and final rounding
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
            z_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            x_out_reg <= '0;
            y_out_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        z_reg     <= Z_BITS'(angle);
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    if (mx_done && my_done)
                    begin
                        x_reg     <= x_fold_next;
                        y_reg     <= y_fold_next;
                        z_reg     <= z_fold_next;
                        step_reg  <= '0;
                        state_reg <= ST_ITER;
                    end
                end
                ST_ITER:
                begin
                    x_reg    <= x_iter_next;
                    y_reg    <= y_iter_next;
                    z_reg    <= z_iter_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                        state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    x_out_reg <= x_sat_next;
                    y_out_reg <= y_sat_next;
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign x_out = x_out_reg;
    assign y_out = y_out_reg;

endmodule

// ===== hw/rtl/camera_vector_rotator_unit.sv =====
// Top level of the camera vector rotator: handshakes, configuration, vector state.
//
// Holds the camera direction and plane vectors (signed Q2.14) and answers every input
// transaction with one output transaction carrying the current vectors and a turned flag.
// A load transaction, or a move that does not turn (mouse look off or pointer at the
// centre column), goes from acceptance straight to the result state, which registers
// its result once the output register is free. A turning move forms the angle, starts
// the rotators, runs a bit-serial gain multiply (one multiplier bit per cycle), folds
// the angle, runs the 16 CORDIC micro-steps (one per cycle), rounds, collects the
// rotated vectors and then registers the result. Direction and plane rotate in two
// CORDIC units side by side. One transaction is in work at a time; a finished result
// sits in the output register, so the next input transaction is taken while it waits.
// Configuration writes are taken every cycle and belong in idle periods.
module camera_vector_rotator_unit
    import cvr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [11:0] mouse_column,
    input  logic signed [15:0] load_dir_x,
    input  logic signed [15:0] load_dir_y,
    input  logic signed [15:0] load_plane_x,
    input  logic signed [15:0] load_plane_y,

    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] dir_x_out,
    output logic signed [15:0] dir_y_out,
    output logic signed [15:0] plane_x_out,
    output logic signed [15:0] plane_y_out,
    output logic        turned
);

    typedef enum logic [1:0] {ST_IDLE, ST_ANGLE, ST_ROT, ST_RESULT} state_t;

    state_t      state_reg;
    logic [11:0] center_column_reg;
    logic [15:0] angle_step_reg;
    logic        mouse_look_on_reg;
    logic [11:0] col_reg;
    angle_t      angle_reg;
    logic        cord_start_reg;
    logic        turned_reg;

    vec_t dir_x_reg;
    vec_t dir_y_reg;
    vec_t plane_x_reg;
    vec_t plane_y_reg;

    logic        out_valid_reg;
    logic [15:0] dir_x_out_reg;
    logic [15:0] dir_y_out_reg;
    logic [15:0] plane_x_out_reg;
    logic [15:0] plane_y_out_reg;
    logic        turned_out_reg;

    logic                in_fire;
    logic                out_free;
    logic signed [12:0]  diff;
    logic signed [29:0]  angle_prod;
    angle_t              angle_next;

    logic dir_done;
    logic plane_done;
    vec_t dir_x_rot;
    vec_t dir_y_rot;
    vec_t plane_x_rot;
    vec_t plane_y_rot;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Angle = step * (centre - column), wrapped to a signed 24-bit turn fraction
    assign diff       = $signed({1'b0, center_column_reg}) - $signed({1'b0, col_reg});
    assign angle_prod = $signed({1'b0, angle_step_reg}) * diff;
    assign angle_next = angle_prod[ANGLE_BITS-1:0];

    cvr_cordic u_rot_dir (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start_reg),
        .angle (angle_reg),
        .x_in  (dir_x_reg),
        .y_in  (dir_y_reg),
        .done  (dir_done),
        .x_out (dir_x_rot),
        .y_out (dir_y_rot)
    );

    cvr_cordic u_rot_plane (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start_reg),
        .angle (angle_reg),
        .x_in  (plane_x_reg),
        .y_in  (plane_y_reg),
        .done  (plane_done),
        .x_out (plane_x_rot),
        .y_out (plane_y_rot)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_column_reg <= 12'd640;
            angle_step_reg    <= 16'd100;
            mouse_look_on_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CENTER_COLUMN: center_column_reg <= cfg_data[11:0];
                CFG_ANGLE_STEP:    angle_step_reg    <= cfg_data;
                CFG_MOUSE_LOOK_ON: mouse_look_on_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Transaction sequencing, vector state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            col_reg         <= '0;
            angle_reg       <= '0;
            cord_start_reg  <= 1'b0;
            turned_reg      <= 1'b0;
            dir_x_reg       <= DIR_X_RST;
            dir_y_reg       <= DIR_Y_RST;
            plane_x_reg     <= PLANE_X_RST;
            plane_y_reg     <= PLANE_Y_RST;
            out_valid_reg   <= 1'b0;
            dir_x_out_reg   <= '0;
            dir_y_out_reg   <= '0;
            plane_x_out_reg <= '0;
            plane_y_out_reg <= '0;
            turned_out_reg  <= 1'b0;
        end
        else
        begin
            cord_start_reg <= 1'b0;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        col_reg    <= mouse_column;
                        turned_reg <= 1'b0;
                        if (kind)
                        begin
                            dir_x_reg   <= sat_int(longint'(load_dir_x));
                            dir_y_reg   <= sat_int(longint'(load_dir_y));
                            plane_x_reg <= sat_int(longint'(load_plane_x));
                            plane_y_reg <= sat_int(longint'(load_plane_y));
                            state_reg   <= ST_RESULT;
                        end
                        else if (mouse_look_on_reg && (mouse_column != center_column_reg))
                            state_reg <= ST_ANGLE;
                        else
                            state_reg <= ST_RESULT;
                    end
                end
                ST_ANGLE:
                begin
                    angle_reg      <= angle_next;
                    cord_start_reg <= 1'b1;
                    state_reg      <= ST_ROT;
                end
                ST_ROT:
                begin
                    if (dir_done && plane_done)
                    begin
                        dir_x_reg   <= dir_x_rot;
                        dir_y_reg   <= dir_y_rot;
                        plane_x_reg <= plane_x_rot;
                        plane_y_reg <= plane_y_rot;
                        turned_reg  <= 1'b1;
                        state_reg   <= ST_RESULT;
                    end
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        dir_x_out_reg   <= out16(dir_x_reg);
                        dir_y_out_reg   <= out16(dir_y_reg);
                        plane_x_out_reg <= out16(plane_x_reg);
                        plane_y_out_reg <= out16(plane_y_reg);
                        turned_out_reg  <= turned_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign dir_x_out   = dir_x_out_reg;
    assign dir_y_out   = dir_y_out_reg;
    assign plane_x_out = plane_x_out_reg;
    assign plane_y_out = plane_y_out_reg;
    assign turned      = turned_out_reg;

    // The two rotators run in lockstep
    assert property (@(posedge clk) disable iff (!rst_n) dir_done == plane_done)
        else $error("direction and plane rotators finished on different cycles");

    // A rotator only finishes while a turning move is in work
    assert property (@(posedge clk) disable iff (!rst_n) dir_done |-> state_reg == ST_ROT)
        else $error("rotator finished outside the rotate phase");

    // The input is never ready again in the cycle after a transaction is accepted
    assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> !in_ready)
        else $error("input taken again right after a transaction");

    // A turned result is only produced after a rotation
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && out_free && turned_reg) |-> $past(state_reg) != ST_IDLE)
        else $error("turned flag set without passing through the rotator");

endmodule

// ===== bench/tb_camera_vector_rotator_unit.sv =====
// Self-checking testbench for camera_vector_rotator_unit: directed corners, then random traffic.
module tb_camera_vector_rotator_unit;
    import cvr_pkg::*;

    localparam logic       KIND_MOVE  = 1'b0;
    localparam logic       KIND_LOAD  = 1'b1;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam longint GAIN_Q32   = 64'h9B74EDA8;
    localparam longint QUARTER    = 64'sd4194304;
    localparam longint HALF       = 64'sd8388608;
    localparam int     ROUND_BITS = 16;
    localparam int     ARC_COUNT  = 24;

    localparam vec_t TOP_VEC    = 16'sh7FFF;
    localparam vec_t BOTTOM_VEC = 16'sh8000;

    localparam int MAX_REPORTS   = 10;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 125;

    typedef struct packed {
        vec_t dir_x;
        vec_t dir_y;
        vec_t plane_x;
        vec_t plane_y;
        logic turned;
    } view_t;

    typedef struct packed {
        vec_t x;
        vec_t y;
    } pair_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [11:0] mouse_column;
    vec_t        load_dir_x;
    vec_t        load_dir_y;
    vec_t        load_plane_x;
    vec_t        load_plane_y;
    logic        out_valid;
    logic        out_ready;
    vec_t        dir_x_out;
    vec_t        dir_y_out;
    vec_t        plane_x_out;
    vec_t        plane_y_out;
    logic        turned;

    // Camera state and register copies kept by the bench
    logic [11:0] center_col;
    logic [15:0] step_per_px;
    logic        look_on;
    vec_t        cam_dir_x;
    vec_t        cam_dir_y;
    vec_t        cam_plane_x;
    vec_t        cam_plane_y;

    view_t pending_views[$];
    int    bad_results;
    int    quiet_cycles;
    int    stall_left;
    logic  feed_gaps;
    logic  sink_stalls;

    camera_vector_rotator_unit uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .mouse_column (mouse_column),
        .load_dir_x   (load_dir_x),
        .load_dir_y   (load_dir_y),
        .load_plane_x (load_plane_x),
        .load_plane_y (load_plane_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dir_x_out    (dir_x_out),
        .dir_y_out    (dir_y_out),
        .plane_x_out  (plane_x_out),
        .plane_y_out  (plane_y_out),
        .turned       (turned)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Arctangent of 2^-i in 2^-24 turn units
    function automatic longint arc_turn(input int i);
        longint r;
        case (i)
            0:       r = 2097152;
            1:       r = 1238021;
            2:       r = 654136;
            3:       r = 332050;
            4:       r = 166669;
            5:       r = 83416;
            6:       r = 41718;
            7:       r = 20860;
            8:       r = 10430;
            9:       r = 5215;
            10:      r = 2608;
            11:      r = 1304;
            12:      r = 652;
            13:      r = 326;
            14:      r = 163;
            15:      r = 81;
            16:      r = 41;
            17:      r = 20;
            18:      r = 10;
            19:      r = 5;
            20:      r = 3;
            21:      r = 1;
            22:      r = 1;
            default: r = 0;
        endcase
        return r;
    endfunction

    function automatic vec_t clamp_vec(input longint v);
        if (v > longint'(TOP_VEC))
            return TOP_VEC;
        if (v < longint'(BOTTOM_VEC))
            return BOTTOM_VEC;
        return vec_t'(v);
    endfunction

    // Scale by the inverse CORDIC gain on the magnitude, round half up, keep guard bits
    function automatic longint gain_scale(input vec_t v);
        longint mag;
        mag = (v < 0) ? -longint'(v) : longint'(v);
        mag = (mag * GAIN_Q32 + (64'sd1 <<< (31 - ROUND_BITS))) >>> (32 - ROUND_BITS);
        return (v < 0) ? -mag : mag;
    endfunction

    // Rotate one vector counterclockwise by an angle in 2^-24 turn units
    function automatic pair_t rotate_pair(input vec_t vx, input vec_t vy, input logic [23:0] ang);
        longint x;
        longint y;
        longint z;
        longint t;
        longint xs;
        longint ys;
        int     i;
        pair_t  r;
        x = gain_scale(vx);
        y = gain_scale(vy);
        z = longint'(ang);
        if (z >= HALF)
            z = z - 2 * HALF;
        // Fold into the quarter turn around zero by an exact swap
        if (z > QUARTER)
        begin
            t = x;
            x = -y;
            y = t;
            z = z - QUARTER;
        end
        else if (z < -QUARTER)
        begin
            t = x;
            x = y;
            y = -t;
            z = z + QUARTER;
        end
        for (i = 0; i < CORDIC_STEPS && i < ARC_COUNT; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - arc_turn(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + arc_turn(i);
            end
        end
        x = (x + (64'sd1 <<< (ROUND_BITS - 1))) >>> ROUND_BITS;
        y = (y + (64'sd1 <<< (ROUND_BITS - 1))) >>> ROUND_BITS;
        r.x = clamp_vec(x);
        r.y = clamp_vec(y);
        return r;
    endfunction

    // Advance the camera state by one input transaction and return the view it reports
    function automatic view_t take_item(input logic k, input logic [11:0] col,
                                        input vec_t ldx, input vec_t ldy,
                                        input vec_t lpx, input vec_t lpy);
        view_t       v;
        pair_t       p;
        longint      diff;
        longint      prod;
        logic [23:0] ang;
        v.turned = 1'b0;
        if (k == KIND_LOAD)
        begin
            cam_dir_x   = ldx;
            cam_dir_y   = ldy;
            cam_plane_x = lpx;
            cam_plane_y = lpy;
        end
        else if (look_on && col != center_col)
        begin
            diff = longint'(center_col) - longint'(col);
            prod = longint'(step_per_px) * diff;
            ang  = prod[23:0];
            p = rotate_pair(cam_dir_x, cam_dir_y, ang);
            cam_dir_x = p.x;
            cam_dir_y = p.y;
            p = rotate_pair(cam_plane_x, cam_plane_y, ang);
            cam_plane_x = p.x;
            cam_plane_y = p.y;
            v.turned = 1'b1;
        end
        v.dir_x   = cam_dir_x;
        v.dir_y   = cam_dir_y;
        v.plane_x = cam_plane_x;
        v.plane_y = cam_plane_y;
        return v;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic vec_t pick_component();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return TOP_VEC;
        if (r == 1)
            return BOTTOM_VEC;
        if (r < 6)
            return vec_t'($urandom);
        return vec_t'(int'($urandom_range(0, 40000)) - 20000);
    endfunction

    // Favor the centre and its neighborhood, where turns are small or absent
    function automatic logic [11:0] pick_column();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return center_col;
        if (r < 6)
            return center_col + 12'($urandom_range(0, 128)) - 12'd64;
        return 12'($urandom);
    endfunction

    // Drop the feed and hold until every expected view has come back
    task automatic drain_views();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_views.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_CENTER_COLUMN: center_col  = data[11:0];
            CFG_ANGLE_STEP:    step_per_px = data;
            CFG_MOUSE_LOOK_ON: look_on     = data[0];
            default: ;
        endcase
    endtask

    // Write all registers while idle; the unused index must leave them alone
    task automatic apply_setting(input logic [11:0] c, input logic [15:0] s, input logic l);
        drain_views();
        write_reg(CFG_CENTER_COLUMN, {4'($urandom), c});
        write_reg(CFG_ANGLE_STEP, s);
        write_reg(CFG_UNUSED, 16'($urandom));
        write_reg(CFG_MOUSE_LOOK_ON, {15'($urandom), l});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic k, input logic [11:0] col,
                             input vec_t dx, input vec_t dy, input vec_t px, input vec_t py);
        int gap;
        gap = feed_gaps ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        mouse_column <= col;
        load_dir_x   <= dx;
        load_dir_y   <= dy;
        load_plane_x <= px;
        load_plane_y <= py;
        do
            @(posedge clk);
        while (!in_ready);
        pending_views.push_back(take_item(k, col, dx, dy, px, py));
    endtask

    // Load fields carry noise on a move
    task automatic send_move(input logic [11:0] col);
        send_item(KIND_MOVE, col, vec_t'($urandom), vec_t'($urandom),
                  vec_t'($urandom), vec_t'($urandom));
    endtask

    // Column carries noise on a load
    task automatic send_load(input vec_t dx, input vec_t dy, input vec_t px, input vec_t py);
        send_item(KIND_LOAD, 12'($urandom), dx, dy, px, py);
    endtask

    // Reset registers and vectors: pointer at centre, then one pixel off
    task automatic test_reset_view();
        send_move(12'd640);
        send_move(12'd639);
    endtask

    // Full-scale loads, and a turn starting from them
    task automatic test_load_extremes();
        send_load(TOP_VEC, BOTTOM_VEC, BOTTOM_VEC, TOP_VEC);
        send_move(12'd0);
        send_load(BOTTOM_VEC, BOTTOM_VEC, TOP_VEC, TOP_VEC);
    endtask

    // One pixel is 1/4096 turn: hit the quarter and half turn folds exactly and just past
    task automatic test_quadrant_folds();
        apply_setting(12'd2048, 16'd4096, 1'b1);
        send_load(TOP_VEC, TOP_VEC, BOTTOM_VEC, TOP_VEC);
        send_move(12'd1536);
        send_move(12'd1024);
        send_move(12'd1023);
        send_move(12'd3072);
        send_move(12'd3073);
        send_move(12'd0);
        send_move(12'd4095);
    endtask

    // Zero angle from a zero step and from a full-turn wrap still runs the rotator
    task automatic test_zero_turn();
        apply_setting(12'd2048, 16'd0, 1'b1);
        send_move(12'd0);
        apply_setting(12'd2048, 16'd8192, 1'b1);
        send_move(12'd0);
    endtask

    // Mouse look off: moves leave the vectors, loads still apply
    task automatic test_look_off();
        apply_setting(12'd640, 16'd100, 1'b0);
        send_move(12'd0);
        send_move(12'd4095);
        send_load(pick_component(), pick_component(), pick_component(), pick_component());
    endtask

    task automatic test_random_traffic();
        int          phase;
        int          n;
        logic [11:0] c;
        logic [15:0] s;
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       begin c = 12'd640;  s = 16'd100;    end
                1:       begin c = 12'd0;    s = 16'hFFFF;   end
                2:       begin c = 12'hFFF;  s = 16'd1;      end
                3:       begin c = 12'd2048; s = 16'd4096;   end
                default: begin c = 12'($urandom); s = 16'($urandom); end
            endcase
            apply_setting(c, s, 1'b1);
            // Phase 0 runs without idling, then gaps, then stalls, then both
            feed_gaps   <= (phase != 0 && phase != 2);
            sink_stalls <= (phase >= 2);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    drain_views();
                if ($urandom_range(0, 4) == 0)
                    send_load(pick_component(), pick_component(),
                              pick_component(), pick_component());
                else
                    send_move(pick_column());
            end
        end
    endtask

    // Sink: ready with occasional stalls of random length
    initial
    begin
        out_ready  <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && sink_stalls && $urandom_range(0, 3) == 0)
                stall_left = gap_len();
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each output transaction with the oldest expected view
    always @(posedge clk)
    begin : check_view
        view_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_views.size() == 0)
            begin
                bad_results++;
                if (bad_results <= MAX_REPORTS)
                    $display("unexpected view: dir (%0d,%0d) plane (%0d,%0d) turned %0b",
                             dir_x_out, dir_y_out, plane_x_out, plane_y_out, turned);
            end
            else
            begin
                want = pending_views.pop_front();
                if (dir_x_out !== want.dir_x || dir_y_out !== want.dir_y ||
                    plane_x_out !== want.plane_x || plane_y_out !== want.plane_y ||
                    turned !== want.turned)
                begin
                    bad_results++;
                    if (bad_results <= MAX_REPORTS)
                        $display("wrong view: want dir (%0d,%0d) plane (%0d,%0d) turned %0b, got dir (%0d,%0d) plane (%0d,%0d) turned %0b",
                                 want.dir_x, want.dir_y, want.plane_x, want.plane_y,
                                 want.turned, dir_x_out, dir_y_out, plane_x_out,
                                 plane_y_out, turned);
                end
            end
        end
    end

    // Watchdog: end the run after too long without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("camera_vector_rotator_unit: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_CENTER_COLUMN;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        kind         <= KIND_MOVE;
        mouse_column <= '0;
        load_dir_x   <= '0;
        load_dir_y   <= '0;
        load_plane_x <= '0;
        load_plane_y <= '0;
        feed_gaps    <= 1'b0;
        sink_stalls  <= 1'b0;
        bad_results  = 0;
        quiet_cycles = 0;
        center_col   = 12'd640;
        step_per_px  = 16'd100;
        look_on      = 1'b1;
        cam_dir_x    = 16'sd16384;
        cam_dir_y    = 16'sd0;
        cam_plane_x  = 16'sd0;
        cam_plane_y  = 16'sd10813;
        repeat (11) @(posedge clk);
        rst_n       <= 1'b1;
        feed_gaps   <= 1'b1;
        sink_stalls <= 1'b1;

        test_reset_view();
        test_load_extremes();
        test_quadrant_folds();
        test_zero_turn();
        test_look_off();
        test_random_traffic();

        drain_views();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (bad_results == 0 && pending_views.size() == 0)
            $display("camera_vector_rotator_unit: match");
        else
            $display("camera_vector_rotator_unit: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/cvr_pkg.sv
hw/rtl/cvr_gain_mult.sv
hw/rtl/cvr_cordic.sv
hw/rtl/camera_vector_rotator_unit.sv
bench/tb_camera_vector_rotator_unit.sv
